/* rtl/fpt_pkg.sv */
// ----------------------------------------------------------------------------
// fpt_pkg: shared types and constants of the four-level page table manager
// Request/response payloads, config register codes, status codes, FSM states
// and the fixed geometry of a 4 KB granule table.
// ----------------------------------------------------------------------------
package fpt_pkg;

  // Geometry
  localparam int unsigned POOL_PAGES_DEF = 16;
  localparam int unsigned TABLE_ENTRIES  = 512;
  localparam int unsigned IDX_W          = 9;
  localparam int unsigned ADDR_W         = 48;
  localparam int unsigned PG_OFS_W       = 12;
  localparam int unsigned PN_W           = ADDR_W - PG_OFS_W;
  localparam int unsigned DESC_W         = 64;
  localparam int unsigned CFG_IDX_W      = 1;

  // Index shift of each walk level
  localparam int unsigned LEVEL_SHIFT [4] = '{39, 30, 21, 12};

  // Descriptor bits
  localparam int unsigned DESC_VALID_BIT = 0;
  localparam int unsigned DESC_TABLE_BIT = 1;

  typedef enum logic [1:0] {
    FUNC_TRANSLATE = 2'd0,
    FUNC_MAP       = 2'd1,
    FUNC_UNMAP     = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    STS_OK            = 2'd0,
    STS_NOT_MAPPED    = 2'd1,
    STS_POOL_EXHAUST  = 2'd2,
    STS_NOT_READY     = 2'd3
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PAGING_READY = 1'd0,
    CFG_POOL_BASE    = 1'd1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    FSM_CLEAR,
    FSM_IDLE,
    FSM_READ,
    FSM_EVAL,
    FSM_ZERO,
    FSM_LINK,
    FSM_LEAF,
    FSM_RESP
  } fsm_e;

  typedef struct packed {
    logic [1:0]        func;
    logic [ADDR_W-1:0] virt_addr;
    logic [ADDR_W-1:0] phys_addr;
    logic [DESC_W-1:0] attr_flags;
  } req_t;

  typedef struct packed {
    logic [ADDR_W-1:0] result_addr;
    logic [1:0]        status;
  } rsp_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [ADDR_W-1:0]    data;
  } cfg_t;

endpackage

/* rtl/fpt_stream_if.sv */
// ----------------------------------------------------------------------------
// fpt_stream_if: valid/ready channel
// Carries one payload of a configurable type from a source to a sink.
// ----------------------------------------------------------------------------
interface fpt_stream_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface

/* rtl/four_level_page_table_manager.sv */
// ----------------------------------------------------------------------------
// four_level_page_table_manager: four-level 4 KB granule page table engine
// Keeps the tables in an on-chip store of POOL_PAGES pages of 512 entries.
// ----------------------------------------------------------------------------
// Usage:
//   req_i  : request channel (func, virt_addr, phys_addr, attr_flags).
//   rsp_o  : one response per request (result_addr, status), in order.
//   cfg_i  : register writes (0 paging_ready, 1 pool_base); always ready,
//            write only while no request is outstanding.
// Walk: each table level takes a store read state, then an evaluate state.
//   A walk ends in the respond state; a successful map or unmap passes
//   through a leaf write state first. Requests that do no walk go straight
//   to the respond state. Every table that map creates adds a zeroing sweep
//   of the new page plus the link write. The single-port table store sets
//   these steps; one request is in flight.
// Reset: the store is swept to zero, one entry per cycle, over all STORE_DEPTH
//   entries (8192 at the default size); req_i stays not ready meanwhile.
// Stall: a finished response sits in the output register; the next request
//   is accepted and walked while it waits, and its own response holds in the
//   respond state until the output register frees up.
// ----------------------------------------------------------------------------
module four_level_page_table_manager #(
  parameter int unsigned POOL_PAGES = fpt_pkg::POOL_PAGES_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  fpt_stream_if.sink   req_i,
  fpt_stream_if.source rsp_o,
  fpt_stream_if.sink   cfg_i
);

  localparam int unsigned IDX_W       = fpt_pkg::IDX_W;
  localparam int unsigned PN_W        = fpt_pkg::PN_W;
  localparam int unsigned ADDR_W      = fpt_pkg::ADDR_W;
  localparam int unsigned DESC_W      = fpt_pkg::DESC_W;
  localparam int unsigned STORE_DEPTH = POOL_PAGES * fpt_pkg::TABLE_ENTRIES;
  localparam int unsigned AW          = $clog2(STORE_DEPTH);
  localparam int unsigned PW          = (POOL_PAGES > 1) ? $clog2(POOL_PAGES) : 1;
  localparam int unsigned NW          = $clog2(POOL_PAGES + 1);
  localparam int unsigned SLOT_W      = PW + IDX_W;

  // Table index of a virtual address at a given level
  function automatic logic [IDX_W-1:0] lvl_idx(input logic [ADDR_W-1:0] va,
                                               input logic [1:0] lvl);
    logic [ADDR_W-1:0] sh;
    sh = va >> fpt_pkg::LEVEL_SHIFT[lvl];
    return sh[IDX_W-1:0];
  endfunction

  // Store address of an entry of a pool page
  function automatic logic [AW-1:0] slot(input logic [PW-1:0] page,
                                         input logic [IDX_W-1:0] idx);
    logic [SLOT_W-1:0] s;
    s = {page, idx};
    return s[AW-1:0];
  endfunction

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  fpt_pkg::fsm_e      state_q, state_d;
  logic [AW-1:0]      sweep_q;
  logic [NW-1:0]      nfp_q;
  logic               paging_ready_q;
  logic [PN_W-1:0]    pool_base_q;
  logic               out_valid_q;
  fpt_pkg::rsp_t      out_q;

  logic [1:0]         op_q;
  logic [ADDR_W-1:0]  va_q;
  logic [ADDR_W-1:0]  pa_q;
  logic [DESC_W-1:0]  fl_q;
  logic [1:0]         lvl_q;
  logic [PW-1:0]      page_q;
  logic [PW-1:0]      new_page_q;
  logic [ADDR_W-1:0]  res_addr_q;
  logic [1:0]         res_sts_q;
  logic [DESC_W-1:0]  rdata_q;

  logic [DESC_W-1:0]  store_q [STORE_DEPTH];

  // --------------------------------------------------------------------------
  // Handshakes
  // --------------------------------------------------------------------------
  logic req_fire, cfg_fire, out_free, out_load;
  logic walk;
  logic is_xlate, is_map, is_unmap;

  assign req_fire = req_i.valid && req_i.ready;
  assign cfg_fire = cfg_i.valid && cfg_i.ready;
  assign out_free = !out_valid_q || rsp_o.ready;
  assign out_load = (state_q == fpt_pkg::FSM_RESP) && out_free;

  assign is_xlate = req_i.payload.func == fpt_pkg::FUNC_TRANSLATE;
  assign is_map   = req_i.payload.func == fpt_pkg::FUNC_MAP;
  assign is_unmap = req_i.payload.func == fpt_pkg::FUNC_UNMAP;
  assign walk     = paging_ready_q && (is_xlate || is_map || is_unmap);

  assign cfg_i.ready   = 1'b1;
  assign rsp_o.valid   = out_valid_q;
  assign rsp_o.payload = out_q;

  // --------------------------------------------------------------------------
  // Descriptor evaluation
  // --------------------------------------------------------------------------
  logic              e_valid, e_table, is_leaf, last_tbl, pool_full;
  logic [PN_W-1:0]   res_diff;
  logic              res_ok;
  logic [PW-1:0]     res_page;
  logic [ADDR_W-1:0] off_mask, leaf_addr;
  logic              ev_done, ev_next, ev_leaf, ev_alloc;
  logic [1:0]        ev_sts;
  logic [ADDR_W-1:0] ev_addr;

  assign e_valid   = rdata_q[fpt_pkg::DESC_VALID_BIT];
  assign e_table   = rdata_q[fpt_pkg::DESC_TABLE_BIT];
  assign res_diff  = rdata_q[ADDR_W-1:fpt_pkg::PG_OFS_W] - pool_base_q;
  assign res_ok    = res_diff < PN_W'(POOL_PAGES);
  assign res_page  = res_diff[PW-1:0];
  assign is_leaf   = (lvl_q == 2'd3) || (((lvl_q == 2'd1) || (lvl_q == 2'd2)) && !e_table);
  assign last_tbl  = lvl_q == 2'd2;
  assign pool_full = nfp_q >= NW'(POOL_PAGES);
  assign off_mask  = (ADDR_W'(1) << fpt_pkg::LEVEL_SHIFT[lvl_q]) - ADDR_W'(1);
  assign leaf_addr = {rdata_q[ADDR_W-1:fpt_pkg::PG_OFS_W], {fpt_pkg::PG_OFS_W{1'b0}}}
                   | (va_q & off_mask);

  always_comb begin
    ev_done  = 1'b0;
    ev_next  = 1'b0;
    ev_leaf  = 1'b0;
    ev_alloc = 1'b0;
    ev_sts   = fpt_pkg::STS_OK;
    ev_addr  = '0;
    case (op_q)
      fpt_pkg::FUNC_TRANSLATE: begin
        if (!e_valid) begin
          ev_done = 1'b1;
          ev_sts  = fpt_pkg::STS_NOT_MAPPED;
        end else if (is_leaf) begin
          ev_done = 1'b1;
          ev_addr = leaf_addr;
        end else if (!res_ok) begin
          ev_done = 1'b1;
          ev_sts  = fpt_pkg::STS_NOT_MAPPED;
        end else begin
          ev_next = 1'b1;
        end
      end
      fpt_pkg::FUNC_MAP: begin
        if (e_valid) begin
          if (!res_ok) begin
            ev_done = 1'b1;
            ev_sts  = fpt_pkg::STS_NOT_MAPPED;
          end else if (last_tbl) begin
            ev_leaf = 1'b1;
          end else begin
            ev_next = 1'b1;
          end
        end else if (pool_full) begin
          ev_done = 1'b1;
          ev_sts  = fpt_pkg::STS_POOL_EXHAUST;
        end else begin
          ev_alloc = 1'b1;
        end
      end
      fpt_pkg::FUNC_UNMAP: begin
        if (!e_valid || !res_ok) begin
          ev_done = 1'b1;
          ev_sts  = fpt_pkg::STS_NOT_MAPPED;
        end else if (last_tbl) begin
          ev_leaf = 1'b1;
        end else begin
          ev_next = 1'b1;
        end
      end
      default: begin
        ev_done = 1'b1;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      fpt_pkg::FSM_CLEAR: if (sweep_q == AW'(STORE_DEPTH - 1)) state_d = fpt_pkg::FSM_IDLE;
      fpt_pkg::FSM_IDLE: begin
        if (req_fire) state_d = walk ? fpt_pkg::FSM_READ : fpt_pkg::FSM_RESP;
      end
      fpt_pkg::FSM_READ: state_d = fpt_pkg::FSM_EVAL;
      fpt_pkg::FSM_EVAL: begin
        if (ev_done)       state_d = fpt_pkg::FSM_RESP;
        else if (ev_leaf)  state_d = fpt_pkg::FSM_LEAF;
        else if (ev_alloc) state_d = fpt_pkg::FSM_ZERO;
        else               state_d = fpt_pkg::FSM_READ;
      end
      fpt_pkg::FSM_ZERO: begin
        if (sweep_q[IDX_W-1:0] == '1) state_d = fpt_pkg::FSM_LINK;
      end
      fpt_pkg::FSM_LINK: state_d = last_tbl ? fpt_pkg::FSM_LEAF : fpt_pkg::FSM_READ;
      fpt_pkg::FSM_LEAF: state_d = fpt_pkg::FSM_RESP;
      fpt_pkg::FSM_RESP: if (out_free) state_d = fpt_pkg::FSM_IDLE;
      default:           state_d = fpt_pkg::FSM_CLEAR;
    endcase
  end

  // --------------------------------------------------------------------------
  // Outputs: store port and request ready
  // --------------------------------------------------------------------------
  logic              mem_we;
  logic [AW-1:0]     mem_addr;
  logic [DESC_W-1:0] mem_wdata;
  logic [PN_W-1:0]   link_pn;

  assign link_pn = pool_base_q + PN_W'(new_page_q);

  always_comb begin
    mem_we      = 1'b0;
    mem_addr    = slot(page_q, lvl_idx(va_q, lvl_q));
    mem_wdata   = '0;
    req_i.ready = 1'b0;
    unique case (state_q)
      fpt_pkg::FSM_CLEAR: begin
        mem_we   = 1'b1;
        mem_addr = sweep_q;
      end
      fpt_pkg::FSM_IDLE: req_i.ready = 1'b1;
      fpt_pkg::FSM_ZERO: begin
        mem_we   = 1'b1;
        mem_addr = slot(new_page_q, sweep_q[IDX_W-1:0]);
      end
      fpt_pkg::FSM_LINK: begin
        mem_we    = 1'b1;
        mem_wdata = {{(DESC_W - ADDR_W){1'b0}}, link_pn, {fpt_pkg::PG_OFS_W{1'b0}}};
        mem_wdata[fpt_pkg::DESC_VALID_BIT] = 1'b1;
        mem_wdata[fpt_pkg::DESC_TABLE_BIT] = 1'b1;
      end
      fpt_pkg::FSM_LEAF: begin
        mem_we   = 1'b1;
        mem_addr = slot(page_q, lvl_idx(va_q, 2'd3));
        if (op_q == fpt_pkg::FUNC_MAP) begin
          mem_wdata = {fl_q[DESC_W-1:ADDR_W],
                       pa_q[ADDR_W-1:fpt_pkg::PG_OFS_W]
                         | fl_q[ADDR_W-1:fpt_pkg::PG_OFS_W],
                       fl_q[fpt_pkg::PG_OFS_W-1:0]};
        end
      end
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // Table store: one port, registered read
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      store_q[mem_addr] <= mem_wdata;
    end else begin
      rdata_q <= store_q[mem_addr];
    end
  end

  // --------------------------------------------------------------------------
  // Control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= fpt_pkg::FSM_CLEAR;
      sweep_q        <= '0;
      nfp_q          <= NW'(1);
      paging_ready_q <= 1'b0;
      pool_base_q    <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      // sweep counter: reset pass and page zeroing
      if (state_q == fpt_pkg::FSM_CLEAR || state_q == fpt_pkg::FSM_ZERO) begin
        sweep_q <= sweep_q + AW'(1);
      end else if (state_q == fpt_pkg::FSM_EVAL && ev_alloc) begin
        sweep_q <= '0;
      end
      // bump allocator
      if (state_q == fpt_pkg::FSM_EVAL && ev_alloc) begin
        nfp_q <= nfp_q + NW'(1);
      end
      // config writes
      if (cfg_fire) begin
        unique case (cfg_i.payload.index)
          fpt_pkg::CFG_PAGING_READY: paging_ready_q <= cfg_i.payload.data[0];
          fpt_pkg::CFG_POOL_BASE:
            pool_base_q <= cfg_i.payload.data[ADDR_W-1:fpt_pkg::PG_OFS_W];
        endcase
      end
      // output register
      if (out_load)         out_valid_q <= 1'b1;
      else if (rsp_o.ready) out_valid_q <= 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Request context and result registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      fpt_pkg::FSM_IDLE: begin
        if (req_fire) begin
          op_q       <= req_i.payload.func;
          va_q       <= req_i.payload.virt_addr;
          pa_q       <= req_i.payload.phys_addr;
          fl_q       <= req_i.payload.attr_flags;
          lvl_q      <= 2'd0;
          page_q     <= '0;
          res_addr_q <= is_xlate ? req_i.payload.virt_addr : '0;
          res_sts_q  <= (is_map || is_unmap) ? fpt_pkg::STS_NOT_READY : fpt_pkg::STS_OK;
        end
      end
      fpt_pkg::FSM_EVAL: begin
        if (ev_done) begin
          res_addr_q <= ev_addr;
          res_sts_q  <= ev_sts;
        end
        if (ev_next) begin
          page_q <= res_page;
          lvl_q  <= lvl_q + 2'd1;
        end
        if (ev_leaf) page_q <= res_page;
        if (ev_alloc) new_page_q <= nfp_q[PW-1:0];
      end
      fpt_pkg::FSM_LINK: begin
        page_q <= new_page_q;
        lvl_q  <= lvl_q + 2'd1;
      end
      fpt_pkg::FSM_LEAF: begin
        res_addr_q <= '0;
        res_sts_q  <= fpt_pkg::STS_OK;
      end
      default: ;
    endcase
    if (out_load) begin
      out_q.result_addr <= res_addr_q;
      out_q.status      <= res_sts_q;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_nfp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (nfp_q >= NW'(1)) && (nfp_q <= NW'(POOL_PAGES)))
    else $error("free page pointer out of range");

  a_alloc_on_map: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (nfp_q != $past(nfp_q)) |->
      ($past(state_q) == fpt_pkg::FSM_EVAL) && (op_q == fpt_pkg::FUNC_MAP))
    else $error("pool page allocated outside a map walk");

  a_leaf_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == fpt_pkg::FSM_EVAL) && (lvl_q == 2'd3) |-> (op_q == fpt_pkg::FUNC_TRANSLATE))
    else $error("map or unmap walked past level 2");

  a_zero_in_pool: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == fpt_pkg::FSM_ZERO) |-> (NW'(new_page_q) < NW'(POOL_PAGES)))
    else $error("zeroing a page outside the pool");

endmodule
